// ----- rtl/hmvt_pkg.sv -----
// Shared types and constants for the homogeneous matrix-vector transform.
`timescale 1ns / 1ps

package hmvt_pkg;

    localparam int COMPONENT_WIDTH_DEF = 32;
    localparam int COEFF_WIDTH_DEF     = 16;
    localparam int ROW_WIDTH           = 64;
    localparam int LANE_WIDTH          = 16;
    localparam int COEFF_INT_BITS      = 4;
    localparam int QUEUE_DEPTH         = 4;
    localparam int CFG_INDEX_WIDTH     = 2;
    localparam logic [LANE_WIDTH-1:0] ONE_Q4_12 = 16'h1000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ROW0,
        REG_ROW1,
        REG_ROW2,
        REG_ROW3
    } reg_index_t;

    typedef struct packed {
        logic div;
        logic sat;
        logic zw;
    } hmvt_ctrl_t;

    function automatic logic [ROW_WIDTH-1:0] row_reset(input logic [1:0] row);
        logic [ROW_WIDTH-1:0] value;
        value = ROW_WIDTH'(ONE_Q4_12) << (LANE_WIDTH * int'(row));
        return value;
    endfunction

endpackage

// ----- rtl/hmvt_front.sv -----
// Front end: matrix registers, multiply-accumulate pipeline and item classification.
`timescale 1ns / 1ps

module hmvt_front
    import hmvt_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int KW = COEFF_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  reg_index_t           cfg_index,
    input  logic [ROW_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] in_x,
    input  logic signed [CW-1:0] in_y,
    input  logic signed [CW-1:0] in_z,
    input  logic signed [CW-1:0] in_w,
    input  logic                 divide_enable,
    input  logic                 q_room,
    output logic                 push,
    output logic [4*(CW+KW+2)-1:0] acc_out,
    output logic [4*CW-1:0]      res_out,
    output hmvt_ctrl_t           ctrl_out
);

    localparam int PW = CW + KW;
    localparam int AW = CW + KW + 2;
    localparam int CF = CW / 2;
    localparam int KF = KW - COEFF_INT_BITS;
    localparam int RP = AW - KF + 1;
    localparam logic signed [RP-1:0] PMAX = RP'((longint'(1) << (CW - 1)) - 1);
    localparam logic signed [RP-1:0] PMIN = -PMAX - RP'(1);
    localparam logic signed [CW-1:0] CMAX = CW'((longint'(1) << (CW - 1)) - 1);
    localparam logic signed [CW-1:0] CMIN = -CMAX - CW'(1);
    localparam logic [CW-1:0] ONE_OUT = CW'(1) << CF;
    localparam logic [AW-1:0] ONE_ACC = AW'(1) << (CF + KF);
    localparam logic [AW:0] HALF_LSB = (AW + 1)'(1) << (KF - 1);

    logic [ROW_WIDTH-1:0] row_reg [4];
    logic signed [CW-1:0] vin [4];
    logic en_f;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic d1_reg, d2_reg, d3_reg;
    logic signed [PW-1:0] prod_reg [4][4];
    logic signed [PW:0]   pair_reg [4][2];
    logic signed [AW-1:0] acc_reg  [4];
    logic [4*AW-1:0] acc4_reg;
    logic [4*CW-1:0] res4_reg;
    hmvt_ctrl_t ctrl4_reg;

    logic signed [AW:0]   rnd [4];
    logic signed [RP-1:0] rs  [4];
    logic [4*CW-1:0] res_next;
    logic [4*AW-1:0] acc_next;
    hmvt_ctrl_t ctrl_next;

    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;
    assign vin[3] = in_w;

    assign push     = v4_reg && q_room;
    assign en_f     = !v4_reg || q_room;
    assign in_stall = !en_f;
    assign acc_out  = acc4_reg;
    assign res_out  = res4_reg;
    assign ctrl_out = ctrl4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
            begin
                row_reg[r] <= row_reset(2'(r));
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                REG_ROW3: row_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en_f)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            d1_reg <= divide_enable;
            d2_reg <= d1_reg;
            d3_reg <= d2_reg;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PW'(vin[c])
                        * PW'($signed(row_reg[r][LANE_WIDTH*c +: KW]));
                end
                pair_reg[r][0] <= (PW + 1)'(prod_reg[r][0]) + (PW + 1)'(prod_reg[r][1]);
                pair_reg[r][1] <= (PW + 1)'(prod_reg[r][2]) + (PW + 1)'(prod_reg[r][3]);
                acc_reg[r]     <= AW'(pair_reg[r][0]) + AW'(pair_reg[r][1]);
            end
            acc4_reg  <= acc_next;
            res4_reg  <= res_next;
            ctrl4_reg <= ctrl_next;
        end
    end

    always_comb
    begin
        logic div_eff;
        logic zero;
        logic sat;
        div_eff = d3_reg && (acc_reg[3] != ONE_ACC);
        zero    = div_eff && (acc_reg[3] == '0);
        sat     = 1'b0;
        res_next = '0;
        for (int r = 0; r < 4; r++)
        begin
            acc_next[r*AW +: AW] = acc_reg[r];
            rnd[r] = (AW + 1)'(acc_reg[r]) + HALF_LSB;
            rs[r]  = rnd[r][AW:KF-1+1];
            if (zero && r < 3)
            begin
                if (acc_reg[r] > 0)
                begin
                    res_next[r*CW +: CW] = CMAX;
                    sat = 1'b1;
                end
                else if (acc_reg[r] < 0)
                begin
                    res_next[r*CW +: CW] = CMIN;
                    sat = 1'b1;
                end
            end
            else if (zero)
            begin
                res_next[r*CW +: CW] = ONE_OUT;
            end
            else if (rs[r] > PMAX)
            begin
                res_next[r*CW +: CW] = CMAX;
                sat = 1'b1;
            end
            else if (rs[r] < PMIN)
            begin
                res_next[r*CW +: CW] = CMIN;
                sat = 1'b1;
            end
            else
            begin
                res_next[r*CW +: CW] = rs[r][CW-1:0];
            end
        end
        ctrl_next.div = div_eff && !zero;
        ctrl_next.sat = sat;
        ctrl_next.zw  = zero;
    end

endmodule

// ----- rtl/hmvt_queue.sv -----
// Small transaction queue between the front end and the divider back end.
`timescale 1ns / 1ps

module hmvt_queue
    import hmvt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             rvalid,
    output logic [WIDTH-1:0] rdata,
    output logic             room
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg, wr_next, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem_reg[rd_reg];
    assign room   = (cnt_reg != CNT_W'(DEPTH)) || pop;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cnt_reg == CNT_W'(DEPTH)) |-> pop)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("Queue count out of range.");

endmodule

// ----- rtl/hmvt_back.sv -----
// Back end: pipelined restoring divider, saturation and the output register.
`timescale 1ns / 1ps

module hmvt_back
    import hmvt_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEF,
    parameter int KW = COEFF_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [4*(CW+KW+2)-1:0] q_acc,
    input  logic [4*CW-1:0]        q_res,
    input  hmvt_ctrl_t             q_ctrl,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [CW-1:0]   out_x,
    output logic signed [CW-1:0]   out_y,
    output logic signed [CW-1:0]   out_z,
    output logic signed [CW-1:0]   out_w,
    output logic                   saturated,
    output logic                   zero_w
);

    localparam int AW = CW + KW + 2;
    localparam int CF = CW / 2;
    localparam int RW = AW + CF + 1;
    localparam int WW = AW + CW + 1;
    localparam int OW = AW + CW - CF;
    localparam int NS = CW + 2;
    localparam logic [CW:0] MAGMAX = (CW + 1)'((longint'(1) << (CW - 1)) - 1);
    localparam logic [CW:0] MAGMIN = (CW + 1)'(1) << (CW - 1);
    localparam logic signed [CW-1:0] CMAX = CW'((longint'(1) << (CW - 1)) - 1);
    localparam logic signed [CW-1:0] CMIN = -CMAX - CW'(1);
    localparam logic [CW-1:0] ONE_OUT = CW'(1) << CF;

    logic en_b;
    logic [NS-1:0] vld_reg;
    logic [AW-1:0] den_reg  [NS];
    logic [RW-1:0] rem_reg  [NS][3];
    logic [CW:0]   quo_reg  [NS][3];
    logic [2:0]    neg_reg  [NS];
    logic [2:0]    ovf_reg  [NS];
    hmvt_ctrl_t    ctrl_reg [NS];
    logic [4*CW-1:0] res_reg [NS];

    logic out_valid_reg, sat_reg, zw_reg;
    logic [CW-1:0] ox_reg, oy_reg, oz_reg, ow_reg;

    logic [AW-1:0] num_mag [3];
    logic [AW-1:0] den_mag;
    logic [2:0] neg0, ovf0;
    logic [4*CW-1:0] fin_res;
    logic fin_sat;

    assign en_b      = !out_valid_reg || !out_stall;
    assign pop       = en_b && q_valid;
    assign out_valid = out_valid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;
    assign out_w     = ow_reg;
    assign saturated = sat_reg;
    assign zero_w    = zw_reg;

    always_comb
    begin
        logic signed [AW-1:0] dacc;
        logic signed [AW-1:0] nacc;
        dacc    = q_acc[3*AW +: AW];
        den_mag = dacc[AW-1] ? AW'(-dacc) : dacc;
        for (int k = 0; k < 3; k++)
        begin
            nacc       = q_acc[k*AW +: AW];
            num_mag[k] = nacc[AW-1] ? AW'(-nacc) : nacc;
            neg0[k]    = nacc[AW-1] ^ dacc[AW-1];
            ovf0[k]    = OW'(num_mag[k]) >= (OW'(den_mag) << (CW - CF));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en_b)
        begin
            vld_reg <= {vld_reg[NS-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= neg0;
            ovf_reg[0]  <= ovf0;
            ctrl_reg[0] <= q_ctrl;
            res_reg[0]  <= q_res;
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= RW'(num_mag[k]) << (CF + 1);
                quo_reg[0][k] <= '0;
            end
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_step
        localparam int BIT = CW + 1 - s;
        logic [WW-1:0] dsh;
        logic [WW-1:0] diff [3];
        logic [2:0] take;

        assign dsh = WW'(den_reg[s-1]) << BIT;

        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            assign diff[k] = WW'(rem_reg[s-1][k]) - dsh;
            assign take[k] = WW'(rem_reg[s-1][k]) >= dsh;
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                ctrl_reg[s] <= ctrl_reg[s-1];
                res_reg[s]  <= res_reg[s-1];
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[s][k] <= take[k] ? RW'(diff[k]) : rem_reg[s-1][k];
                    quo_reg[s][k] <= quo_reg[s-1][k] | ((CW + 1)'(take[k]) << BIT);
                end
            end
        end
    end

    always_comb
    begin
        logic [CW+1:0] qp1;
        logic [CW:0] mag;
        fin_sat = 1'b0;
        fin_res = '0;
        for (int k = 0; k < 3; k++)
        begin
            qp1 = (CW + 2)'(quo_reg[NS-1][k]) + (CW + 2)'(1);
            mag = qp1[CW+1:1];
            if (ovf_reg[NS-1][k])
            begin
                fin_res[k*CW +: CW] = neg_reg[NS-1][k] ? CMIN : CMAX;
                fin_sat = 1'b1;
            end
            else if (!neg_reg[NS-1][k])
            begin
                if (mag > MAGMAX)
                begin
                    fin_res[k*CW +: CW] = CMAX;
                    fin_sat = 1'b1;
                end
                else
                begin
                    fin_res[k*CW +: CW] = mag[CW-1:0];
                end
            end
            else if (mag > MAGMIN)
            begin
                fin_res[k*CW +: CW] = CMIN;
                fin_sat = 1'b1;
            end
            else
            begin
                fin_res[k*CW +: CW] = -mag[CW-1:0];
            end
        end
        fin_res[3*CW +: CW] = ONE_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            out_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            if (ctrl_reg[NS-1].div)
            begin
                ox_reg  <= fin_res[0 +: CW];
                oy_reg  <= fin_res[CW +: CW];
                oz_reg  <= fin_res[2*CW +: CW];
                ow_reg  <= fin_res[3*CW +: CW];
                sat_reg <= fin_sat;
                zw_reg  <= 1'b0;
            end
            else
            begin
                ox_reg  <= res_reg[NS-1][0 +: CW];
                oy_reg  <= res_reg[NS-1][CW +: CW];
                oz_reg  <= res_reg[NS-1][2*CW +: CW];
                ow_reg  <= res_reg[NS-1][3*CW +: CW];
                sat_reg <= ctrl_reg[NS-1].sat;
                zw_reg  <= ctrl_reg[NS-1].zw;
            end
        end
    end

endmodule

// ----- rtl/homogeneous_matrix_vector_transform.sv -----
// Top level of the homogeneous 4x4 matrix-vector transform.
//
//   Channel  Handshake                 Payload
//   in       in_valid / in_stall       in_x, in_y, in_z, in_w, divide_enable
//   out      out_valid / out_stall     out_x, out_y, out_z, out_w, saturated, zero_w
//   cfg      cfg_write                 cfg_index, cfg_data
//
// One transaction per cycle is sustained in both directions while out_stall is low.
// A transaction passes in order through the front pipeline, the queue, the divider stages and the output register.
// The divider spends one stage per quotient bit, COMPONENT_WIDTH + 1 stages in all.
// A stalled output freezes the back end; the front keeps going until the queue is full.
// Reset restores the identity matrix and empties every stage.
`timescale 1ns / 1ps

module homogeneous_matrix_vector_transform
    import hmvt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
    parameter int COEFF_WIDTH     = COEFF_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  reg_index_t                        cfg_index,
    input  logic [ROW_WIDTH-1:0]              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] in_x,
    input  logic signed [COMPONENT_WIDTH-1:0] in_y,
    input  logic signed [COMPONENT_WIDTH-1:0] in_z,
    input  logic signed [COMPONENT_WIDTH-1:0] in_w,
    input  logic                              divide_enable,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COMPONENT_WIDTH-1:0] out_x,
    output logic signed [COMPONENT_WIDTH-1:0] out_y,
    output logic signed [COMPONENT_WIDTH-1:0] out_z,
    output logic signed [COMPONENT_WIDTH-1:0] out_w,
    output logic                              saturated,
    output logic                              zero_w
);

    localparam int AW = COMPONENT_WIDTH + COEFF_WIDTH + 2;
    localparam int CTRL_W = $bits(hmvt_ctrl_t);
    localparam int QW = 4 * AW + 4 * COMPONENT_WIDTH + CTRL_W;

    logic push, pop, room, q_valid;
    logic [4*AW-1:0] f_acc;
    logic [4*COMPONENT_WIDTH-1:0] f_res;
    hmvt_ctrl_t f_ctrl;
    logic [QW-1:0] q_rdata;

    hmvt_front #(
        .CW (COMPONENT_WIDTH),
        .KW (COEFF_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_x          (in_x),
        .in_y          (in_y),
        .in_z          (in_z),
        .in_w          (in_w),
        .divide_enable (divide_enable),
        .q_room        (room),
        .push          (push),
        .acc_out       (f_acc),
        .res_out       (f_res),
        .ctrl_out      (f_ctrl)
    );

    hmvt_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  ({f_ctrl, f_res, f_acc}),
        .pop    (pop),
        .rvalid (q_valid),
        .rdata  (q_rdata),
        .room   (room)
    );

    hmvt_back #(
        .CW (COMPONENT_WIDTH),
        .KW (COEFF_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_acc     (q_rdata[0 +: 4*AW]),
        .q_res     (q_rdata[4*AW +: 4*COMPONENT_WIDTH]),
        .q_ctrl    (hmvt_ctrl_t'(q_rdata[QW-1 -: CTRL_W])),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w),
        .saturated (saturated),
        .zero_w    (zero_w)
    );

endmodule

// ----- tb/homogeneous_matrix_vector_transform_tb.sv -----
// Self-checking testbench for the homogeneous 4x4 matrix-vector transform.
`timescale 1ns / 1ps

module homogeneous_matrix_vector_transform_tb;
    import hmvt_pkg::*;

    localparam int CW = 32;
    localparam int FRAC = 16;
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint ONE_ACC = 64'sd1 << 28;
    localparam int LATENCY = 60;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [CW-1:0] w;
        logic          sat;
        logic          zw;
    } vertex_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    reg_index_t cfg_index;
    logic [ROW_WIDTH-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] in_x, in_y, in_z, in_w;
    logic divide_enable;
    logic out_valid;
    logic out_stall;
    logic signed [CW-1:0] out_x, out_y, out_z, out_w;
    logic saturated;
    logic zero_w;

    logic [ROW_WIDTH-1:0] matrix [4];
    vertex_result_t expected_vertices [$];
    int errors;
    longint cycles;
    int hold_off;
    int rx_wait;

    homogeneous_matrix_vector_transform dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("homogeneous_matrix_vector_transform regression: fail");
            $finish;
        end
    end

    function automatic longint clamp_component(longint v, inout logic sat);
        if (v > CMAX)
        begin
            sat = 1'b1;
            return CMAX;
        end
        if (v < CMIN)
        begin
            sat = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    function automatic longint divide_round(longint num, longint den, inout logic sat);
        logic neg;
        longint unsigned ua, ub, qi, r, mag;
        neg = (num < 0) != (den < 0);
        ua = num < 0 ? -num : num;
        ub = den < 0 ? -den : den;
        qi = ua / ub;
        r = ua % ub;
        if (qi > (64'd1 << (CW - 1 - FRAC)))
            mag = 64'd1 << CW;
        else
        begin
            mag = qi << FRAC;
            for (int i = FRAC - 1; i >= 0; i--)
            begin
                r = r << 1;
                if (r >= ub)
                begin
                    r -= ub;
                    mag |= 64'd1 << i;
                end
            end
            r = r << 1;
            if (r >= ub)
                mag++;
        end
        return clamp_component(neg ? -longint'(mag) : longint'(mag), sat);
    endfunction

    function automatic vertex_result_t transform_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy,
                                                        logic [CW-1:0] vz, logic [CW-1:0] vw,
                                                        logic dv);
        longint comp [4];
        longint acc [4];
        longint res [4];
        logic sat;
        logic zw;
        vertex_result_t t;
        comp[0] = longint'(signed'(vx));
        comp[1] = longint'(signed'(vy));
        comp[2] = longint'(signed'(vz));
        comp[3] = longint'(signed'(vw));
        sat = 1'b0;
        zw = 1'b0;
        for (int r = 0; r < 4; r++)
        begin
            acc[r] = 0;
            for (int c = 0; c < 4; c++)
                acc[r] += longint'(signed'(matrix[r][16*c +: 16])) * comp[c];
        end
        if (dv && acc[3] != ONE_ACC)
        begin
            res[3] = 64'sd1 << FRAC;
            if (acc[3] == 0)
            begin
                zw = 1'b1;
                for (int r = 0; r < 3; r++)
                begin
                    if (acc[r] > 0)
                    begin
                        res[r] = CMAX;
                        sat = 1'b1;
                    end
                    else if (acc[r] < 0)
                    begin
                        res[r] = CMIN;
                        sat = 1'b1;
                    end
                    else
                        res[r] = 0;
                end
            end
            else
                for (int r = 0; r < 3; r++)
                    res[r] = divide_round(acc[r], acc[3], sat);
        end
        else
            for (int r = 0; r < 4; r++)
                res[r] = clamp_component((acc[r] + (64'sd1 << 11)) >>> 12, sat);
        t.x = res[0][CW-1:0];
        t.y = res[1][CW-1:0];
        t.z = res[2][CW-1:0];
        t.w = res[3][CW-1:0];
        t.sat = sat;
        t.zw = zw;
        return t;
    endfunction

    // The receiver stalls at random per transaction, or for a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        int next_wait;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait <= 0;
        end
        else
        begin
            next_wait = rx_wait;
            if (out_valid && !out_stall)
                next_wait = $urandom_range(0, 19);
            else if (next_wait > 0)
                next_wait = next_wait - 1;
            rx_wait <= next_wait;
            out_stall <= (hold_off > 0) || (next_wait > 0);
        end
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk)
    begin
        vertex_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_vertices.size() == 0)
            begin
                $display("%0t: unexpected transaction x=%h", $time, out_x);
                errors++;
            end
            else
            begin
                want = expected_vertices.pop_front();
                if (want.x !== out_x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, want.x, out_x);
                    errors++;
                end
                if (want.y !== out_y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, want.y, out_y);
                    errors++;
                end
                if (want.z !== out_z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, want.z, out_z);
                    errors++;
                end
                if (want.w !== out_w)
                begin
                    $display("%0t: out_w expected %h actual %h", $time, want.w, out_w);
                    errors++;
                end
                if (want.sat !== saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
                    errors++;
                end
                if (want.zw !== zero_w)
                begin
                    $display("%0t: zero_w expected %b actual %b", $time, want.zw, zero_w);
                    errors++;
                end
            end
        end
    end

    task automatic send_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, logic [CW-1:0] vz,
                               logic [CW-1:0] vw, logic dv, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_x <= vx;
        in_y <= vy;
        in_z <= vz;
        in_w <= vw;
        divide_enable <= dv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_vertices.push_back(transform_vertex(vx, vy, vz, vw, dv));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_row(reg_index_t idx, logic [ROW_WIDTH-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        matrix[idx] = value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CW-1:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            4: return 32'h00010000;
            default: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
        endcase
    endfunction

    function automatic logic [ROW_WIDTH-1:0] random_row(int r);
        logic [ROW_WIDTH-1:0] v;
        for (int c = 0; c < 4; c++)
            case ($urandom_range(0, 3))
                0: v[16*c +: 16] = 16'($urandom);
                1: v[16*c +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
                2: v[16*c +: 16] = (c == r) ? ONE_Q4_12 : 16'h0000;
                default: v[16*c +: 16] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            endcase
        return v;
    endfunction

    task automatic test_identity_directed();
        send_vertex(32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00010000, 1'b0);
        send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00010000, 1'b1);
        send_vertex(32'h00030000, 32'hfffd0000, 32'h00018000, 32'h00020000, 1'b1);
        send_vertex(32'h00050000, 32'hfffb0000, 32'h00000000, 32'h00000000, 1'b1);
        send_vertex(32'h00010000, 32'h00000001, 32'h7fffffff, 32'h00000001, 1'b1);
        send_vertex(32'h00000001, 32'hffffffff, 32'h00000003, 32'hffff0000, 1'b1);
        send_vertex(32'h12345678, 32'h9abcdef0, 32'h0000ffff, 32'h80000000, 1'b1);
        send_vertex(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
        send_vertex(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0);
        wait_drained();
    endtask

    task automatic test_extreme_matrix();
        write_row(REG_ROW0, {4{16'h7fff}});
        write_row(REG_ROW1, {4{16'h8000}});
        write_row(REG_ROW2, 64'h0000_0000_8000_7fff);
        write_row(REG_ROW3, 64'h0000_0000_0000_0000);
        send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        send_vertex(32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1);
        send_vertex(32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1);
        wait_drained();
        write_row(REG_ROW3, 64'h0800_0000_0000_0000);
        send_vertex(32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001, 1'b0);
        send_vertex(32'h00000001, 32'hffffffff, 32'h00000003, 32'h00000002, 1'b1);
        send_vertex(32'h00000800, 32'h00001800, 32'hfffff800, 32'h00020000, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off <= 400;
        for (int i = 0; i < 60; i++)
            send_vertex(random_component(), random_component(), random_component(),
                        random_component(), 1'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_random_vertices();
        for (int phase = 0; phase < 6; phase++)
        begin
            for (int r = 0; r < 4; r++)
                write_row(reg_index_t'(r), random_row(r));
            for (int i = 0; i < 280; i++)
                send_vertex(random_component(), random_component(), random_component(),
                            random_component(), 1'($urandom), i % 50 < 20);
            wait_drained();
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_ROW0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        in_w = '0;
        divide_enable = 1'b0;
        for (int r = 0; r < 4; r++)
            matrix[r] = row_reset(2'(r));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_directed();
        test_extreme_matrix();
        test_backpressure();
        test_random_vertices();
        if (errors == 0)
            $display("homogeneous_matrix_vector_transform regression: pass");
        else
            $display("homogeneous_matrix_vector_transform regression: fail");
        $finish;
    end

endmodule
